@@ rtl/accelerator_lease_pool_macros.svh @@
// Assertion macros shared by the lease pool RTL.
// Each expects clk and rst in scope at the point of use.
`ifndef ACCELERATOR_LEASE_POOL_MACROS_SVH
`define ACCELERATOR_LEASE_POOL_MACROS_SVH

// same-cycle implication
`define ALP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ALP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/alp_pkg.sv @@
// ----------------------------------------------------------------------------
// alp_pkg
// Shared constants, codes and controller/datapath types for the lease pool.
// ----------------------------------------------------------------------------
package alp_pkg;

  localparam int POOL_SIZE_DEF = 8;

  localparam logic [1:0] ACT_LEASE    = 2'd0;
  localparam logic [1:0] ACT_RELEASE  = 2'd1;
  localparam logic [1:0] ACT_ANNOUNCE = 2'd2;

  localparam logic [2:0] ST_GRANTED     = 3'd0;
  localparam logic [2:0] ST_UNAVAILABLE = 3'd1;
  localparam logic [2:0] ST_RETURNED    = 3'd2;
  localparam logic [2:0] ST_NOT_LEASED  = 3'd3;
  localparam logic [2:0] ST_ADDED       = 3'd4;
  localparam logic [2:0] ST_IGNORED     = 3'd5;

  // granted address is 1.1.board.2
  localparam logic [7:0] ADDR_OCT_A = 8'd1;
  localparam logic [7:0] ADDR_OCT_B = 8'd1;
  localparam logic [7:0] ADDR_OCT_D = 8'd2;

  // where the result board number comes from
  localparam logic [1:0] SRC_ZERO = 2'd0;
  localparam logic [1:0] SRC_REQ  = 2'd1;
  localparam logic [1:0] SRC_FREE = 2'd2;

  typedef struct packed {
    logic       capture;
    logic       pop_free;
    logic       push_free;
    logic       push_busy;
    logic       drop_busy;
    logic       busy_rd_next;
    logic       shift_wr;
    logic       idx_inc;
    logic       set_res;
    logic [2:0] res_status;
    logic [1:0] res_src;
    logic       load_out;
  } alp_cmd_t;

  typedef struct packed {
    logic [1:0] act;
    logic       free_empty;
    logic       free_full;
    logic       busy_empty;
    logic       busy_full;
    logic       len_match;
    logic       hit;
    logic       last_search;
    logic       more_shift;
    logic       out_free;
  } alp_sts_t;

endpackage

@@ rtl/alp_if.sv @@
// ----------------------------------------------------------------------------
// alp_if
// Valid/ready channels of the lease pool: request, response, configuration.
// ----------------------------------------------------------------------------
interface alp_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] peer_addr;
  logic [15:0] payload_length;

  modport source (output valid, action, peer_addr, payload_length, input ready);
  modport sink   (input valid, action, peer_addr, payload_length, output ready);
endinterface

interface alp_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  board_num;
  logic [31:0] board_addr;
  logic [3:0]  free_count;
  logic [3:0]  busy_count;

  modport source (output valid, status, board_num, board_addr, free_count, busy_count,
                  input ready);
  modport sink   (input valid, status, board_num, board_addr, free_count, busy_count,
                  output ready);
endinterface

interface alp_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

@@ rtl/alp_ram.sv @@
// ----------------------------------------------------------------------------
// alp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module alp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/alp_ctrl.sv @@
// ----------------------------------------------------------------------------
// alp_ctrl
// Sequencer for lease, release (search and compaction) and announce.
// ----------------------------------------------------------------------------
module alp_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  alp_pkg::alp_sts_t sts,
  output alp_pkg::alp_cmd_t cmd
);
  import alp_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISPATCH = 4'd1;
  localparam logic [3:0] S_LEASE_WR = 4'd2;
  localparam logic [3:0] S_SRCH_RD  = 4'd3;
  localparam logic [3:0] S_SRCH_CK  = 4'd4;
  localparam logic [3:0] S_SHIFT_RD = 4'd5;
  localparam logic [3:0] S_SHIFT_WR = 4'd6;
  localparam logic [3:0] S_REL_DONE = 4'd7;
  localparam logic [3:0] S_FINISH   = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts.act)
          ACT_LEASE: begin
            if (sts.free_empty) begin
              cmd.set_res    = 1'b1;
              cmd.res_status = ST_UNAVAILABLE;
              cmd.res_src    = SRC_ZERO;
              state_next     = S_FINISH;
            end else begin
              cmd.pop_free = 1'b1;
              state_next   = S_LEASE_WR;
            end
          end
          ACT_RELEASE: begin
            if (sts.busy_empty) begin
              cmd.set_res    = 1'b1;
              cmd.res_status = ST_NOT_LEASED;
              cmd.res_src    = SRC_REQ;
              state_next     = S_FINISH;
            end else begin
              state_next = S_SRCH_RD;
            end
          end
          ACT_ANNOUNCE: begin
            cmd.set_res = 1'b1;
            cmd.res_src = SRC_REQ;
            if (sts.len_match && !sts.free_full) begin
              cmd.push_free  = 1'b1;
              cmd.res_status = ST_ADDED;
            end else begin
              cmd.res_status = ST_IGNORED;
            end
            state_next = S_FINISH;
          end
          default: begin
            cmd.set_res    = 1'b1;
            cmd.res_status = ST_IGNORED;
            cmd.res_src    = SRC_ZERO;
            state_next     = S_FINISH;
          end
        endcase
      end
      S_LEASE_WR: begin
        // append dropped when busy list is full
        cmd.push_busy  = !sts.busy_full;
        cmd.set_res    = 1'b1;
        cmd.res_status = ST_GRANTED;
        cmd.res_src    = SRC_FREE;
        state_next     = S_FINISH;
      end
      S_SRCH_RD: begin
        state_next = S_SRCH_CK;
      end
      S_SRCH_CK: begin
        if (sts.hit) begin
          state_next = sts.last_search ? S_REL_DONE : S_SHIFT_RD;
        end else if (sts.last_search) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = ST_NOT_LEASED;
          cmd.res_src    = SRC_REQ;
          state_next     = S_FINISH;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_SRCH_RD;
        end
      end
      S_SHIFT_RD: begin
        cmd.busy_rd_next = 1'b1;
        state_next       = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        cmd.idx_inc  = 1'b1;
        state_next   = sts.more_shift ? S_SHIFT_RD : S_REL_DONE;
      end
      S_REL_DONE: begin
        cmd.drop_busy  = 1'b1;
        cmd.push_free  = !sts.free_full;
        cmd.set_res    = 1'b1;
        cmd.res_status = ST_RETURNED;
        cmd.res_src    = SRC_REQ;
        state_next     = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/alp_dp.sv @@
// ----------------------------------------------------------------------------
// alp_dp
// Datapath: free stack and busy list RAMs, fill counts, search index,
// config register and response register.
// ----------------------------------------------------------------------------
module alp_dp #(
  parameter int POOL_SIZE = alp_pkg::POOL_SIZE_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        in_action,
  input  logic [31:0]       in_peer_addr,
  input  logic [15:0]       in_payload_length,
  input  alp_pkg::alp_cmd_t cmd,
  output alp_pkg::alp_sts_t sts,
  alp_rsp_if.source         rsp,
  alp_cfg_if.sink           cfg
);
  import alp_pkg::*;

  localparam int CW = $clog2(POOL_SIZE + 1);
  localparam int AW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam logic [CW-1:0] FULL = CW'(POOL_SIZE);

  logic [15:0]   cfg_len;
  logic [1:0]    act;
  logic [7:0]    req_board;
  logic [15:0]   plen;
  logic [CW-1:0] free_fill;
  logic [CW-1:0] busy_fill;
  logic [CW-1:0] idx;
  logic [2:0]    res_status;
  logic [7:0]    res_board;
  logic          res_grant;

  logic [CW-1:0] free_top;
  logic [CW-1:0] idx_p1;
  logic [CW:0]   idx_p2;
  logic [7:0]    free_rdata;
  logic [7:0]    busy_rdata;
  logic [AW-1:0] busy_raddr;
  logic [AW-1:0] busy_waddr;
  logic [7:0]    busy_wdata;
  logic          busy_we;

  assign free_top = free_fill - CW'(1);
  assign idx_p1   = idx + CW'(1);
  assign idx_p2   = {1'b0, idx} + (CW+1)'(2);

  alp_ram #(.WIDTH(8), .DEPTH(POOL_SIZE)) u_free_ram (
    .clk   (clk),
    .we    (cmd.push_free),
    .waddr (free_fill[AW-1:0]),
    .wdata (req_board),
    .raddr (free_top[AW-1:0]),
    .rdata (free_rdata)
  );

  assign busy_raddr = cmd.busy_rd_next ? idx_p1[AW-1:0] : idx[AW-1:0];
  assign busy_waddr = cmd.shift_wr ? idx[AW-1:0] : busy_fill[AW-1:0];
  assign busy_wdata = cmd.shift_wr ? busy_rdata : free_rdata;
  assign busy_we    = cmd.shift_wr | cmd.push_busy;

  alp_ram #(.WIDTH(8), .DEPTH(POOL_SIZE)) u_busy_ram (
    .clk   (clk),
    .we    (busy_we),
    .waddr (busy_waddr),
    .wdata (busy_wdata),
    .raddr (busy_raddr),
    .rdata (busy_rdata)
  );

  // config word
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_len <= '0;
    end else if (cfg.valid) begin
      cfg_len <= cfg.data;
    end
  end

  // latched request word
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act       <= in_action;
      req_board <= in_peer_addr[15:8];
      plen      <= in_payload_length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_fill <= '0;
      busy_fill <= '0;
    end else begin
      if (cmd.pop_free) begin
        free_fill <= free_top;
      end else if (cmd.push_free) begin
        free_fill <= free_fill + CW'(1);
      end
      if (cmd.push_busy) begin
        busy_fill <= busy_fill + CW'(1);
      end else if (cmd.drop_busy) begin
        busy_fill <= busy_fill - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx_p1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_res) begin
      res_status <= cmd.res_status;
      res_grant  <= (cmd.res_src == SRC_FREE);
      case (cmd.res_src)
        SRC_REQ:  res_board <= req_board;
        SRC_FREE: res_board <= free_rdata;
        default:  res_board <= '0;
      endcase
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (cmd.load_out) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rsp.status     <= res_status;
      rsp.board_num  <= res_board;
      rsp.board_addr <= res_grant ? {ADDR_OCT_A, ADDR_OCT_B, res_board, ADDR_OCT_D} : '0;
      rsp.free_count <= 4'(free_fill);
      rsp.busy_count <= 4'(busy_fill);
    end
  end

  assign sts.act         = act;
  assign sts.free_empty  = (free_fill == '0);
  assign sts.free_full   = (free_fill >= FULL);
  assign sts.busy_empty  = (busy_fill == '0);
  assign sts.busy_full   = (busy_fill >= FULL);
  assign sts.len_match   = (plen == cfg_len);
  assign sts.hit         = (busy_rdata == req_board);
  assign sts.last_search = (idx_p1 == busy_fill);
  assign sts.more_shift  = (idx_p2 < {1'b0, busy_fill});
  assign sts.out_free    = !rsp.valid || rsp.ready;

endmodule

@@ rtl/accelerator_lease_pool.sv @@
// ----------------------------------------------------------------------------
// accelerator_lease_pool
// Lease bookkeeping for accelerator boards: free stack plus ordered busy list.
// ----------------------------------------------------------------------------
// Usage:
//   req : one word per command (lease, release, announce); the board for
//         release and announce is peer_addr[15:8].
//   rsp : one word per request with status, board, granted address and the
//         fill counts after the command.
//   cfg : expected announce payload length; always ready, write when idle.
// Timing: one request is worked at a time; req.ready is high only when the
//   sequencer is idle. A release reads and checks the busy list entries in
//   order until it finds a match, then compacts the list by moving each
//   later entry down one slot with a read step and a write step. The next
//   request can be taken on the same edge as the response. The single
//   registered read port of the busy list RAM is why a release walks the
//   list one entry at a time.
// Reset: both lists empty, config length 0; no RAM clearing pass.
// Stall: the response sits in an output register; the next request is
//   taken and worked while it waits, and stalls in its last step until the
//   held response is taken.
// ----------------------------------------------------------------------------
`include "accelerator_lease_pool_macros.svh"

module accelerator_lease_pool #(
  parameter int POOL_SIZE = alp_pkg::POOL_SIZE_DEF
) (
  input  logic     clk,
  input  logic     rst,
  alp_req_if.sink  req,
  alp_rsp_if.source rsp,
  alp_cfg_if.sink  cfg
);
  import alp_pkg::*;

  alp_cmd_t cmd;
  alp_sts_t sts;
  logic     in_ready;

  assign req.ready = in_ready;

  alp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  alp_dp #(.POOL_SIZE(POOL_SIZE)) u_dp (
    .clk               (clk),
    .rst               (rst),
    .in_action         (req.action),
    .in_peer_addr      (req.peer_addr),
    .in_payload_length (req.payload_length),
    .cmd               (cmd),
    .sts               (sts),
    .rsp               (rsp),
    .cfg               (cfg)
  );

  `ALP_ASSERT_NEXT(a_one_at_a_time, req.valid && req.ready, !req.ready,
    "request taken while busy")
  `ALP_ASSERT_NOW(a_grant_addr, rsp.valid && (rsp.status == ST_GRANTED),
    (rsp.board_addr[15:8] == rsp.board_num) && (rsp.board_addr[7:0] == ADDR_OCT_D),
    "granted address mismatch")
  `ALP_ASSERT_NOW(a_unavail_zero, rsp.valid && (rsp.status == ST_UNAVAILABLE),
    (rsp.board_num == 8'd0) && (rsp.board_addr == 32'd0) && (rsp.free_count == 4'd0),
    "unavailable with nonzero fields")

endmodule

@@ bench/accelerator_lease_pool_test.sv @@
// ----------------------------------------------------------------------------
// accelerator_lease_pool_test
// Self-checking bench for the lease pool. A behavioral copy of the free stack
// and the ordered busy list predicts one response word per request word;
// responses are checked field by field in order. Directed corner cases come
// first, then random traffic at several announce lengths, then a long
// response back-pressure stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module accelerator_lease_pool_test;
  import alp_pkg::*;

  localparam int POOL_SIZE = POOL_SIZE_DEF;
  localparam int SETTLE_CYCLES = 4 * POOL_SIZE + 8;
  localparam int HOLD_CYCLES = 200;
  localparam longint TIMEOUT_NS = 4_000_000;
  // action code with no command behind it
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  board;
    logic [31:0] addr;
    logic [3:0]  free_cnt;
    logic [3:0]  busy_cnt;
  } lease_result_t;

  logic clk;
  logic rst;

  alp_req_if req_ch ();
  alp_rsp_if rsp_ch ();
  alp_cfg_if cfg_ch ();

  accelerator_lease_pool dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // shadow copy of the block's lists and register
  logic [7:0]  free_stack [POOL_SIZE];
  logic [7:0]  busy_list [POOL_SIZE];
  int          free_depth;
  int          busy_depth;
  logic [15:0] announce_len;

  lease_result_t pending_results [$];
  int          mismatches;

  // receiver pattern control, written only by the main sequence
  int          rsp_stall_max;
  int          hold_requests;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic lease_result_t predict_lease_result(input logic [1:0] act,
                                                         input logic [31:0] peer,
                                                         input logic [15:0] plen);
    lease_result_t r;
    logic [7:0] board;
    int hit;
    r = '0;
    board = peer[15:8];
    hit = -1;
    r.status = ST_IGNORED;
    case (act)
      ACT_LEASE: begin
        if (free_depth == 0) begin
          r.status = ST_UNAVAILABLE;
        end else begin
          free_depth--;
          r.board = free_stack[free_depth];
          // a full busy list drops the append, the grant still goes out
          if (busy_depth < POOL_SIZE) begin
            busy_list[busy_depth] = r.board;
            busy_depth++;
          end
          r.addr = {ADDR_OCT_A, ADDR_OCT_B, r.board, ADDR_OCT_D};
          r.status = ST_GRANTED;
        end
      end
      ACT_RELEASE: begin
        r.board = board;
        for (int i = 0; i < busy_depth; i++)
          if (hit < 0 && busy_list[i] == board) hit = i;
        if (hit < 0) begin
          r.status = ST_NOT_LEASED;
        end else begin
          for (int i = hit; i + 1 < busy_depth; i++) busy_list[i] = busy_list[i + 1];
          busy_depth--;
          if (free_depth < POOL_SIZE) begin
            free_stack[free_depth] = board;
            free_depth++;
          end
          r.status = ST_RETURNED;
        end
      end
      ACT_ANNOUNCE: begin
        r.board = board;
        if (plen == announce_len && free_depth < POOL_SIZE) begin
          free_stack[free_depth] = board;
          free_depth++;
          r.status = ST_ADDED;
        end
      end
      default: ;
    endcase
    r.free_cnt = free_depth[3:0];
    r.busy_cnt = busy_depth[3:0];
    return r;
  endfunction

  function automatic logic [31:0] peer_for(input logic [7:0] board);
    logic [31:0] a;
    a = $urandom;
    a[15:8] = board;
    return a;
  endfunction

  // mostly a handful of board numbers so releases find matches
  function automatic logic [7:0] pick_board();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) return 8'($urandom_range(0, 5));
    else if (sel == 7) return 8'hFF;
    else return 8'($urandom_range(0, 255));
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
      mismatches++;
    end
  endfunction

  // response checker
  always @(posedge clk) begin
    lease_result_t want;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("response word with no request outstanding: status %0d board %0d",
               rsp_ch.status, rsp_ch.board_num);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(rsp_ch.status));
        check_field("board_num", 32'(want.board), 32'(rsp_ch.board_num));
        check_field("board_addr", want.addr, rsp_ch.board_addr);
        check_field("free_count", 32'(want.free_cnt), 32'(rsp_ch.free_count));
        check_field("busy_count", 32'(want.busy_cnt), 32'(rsp_ch.busy_count));
      end
    end
  end

  // response ready: alternating on/off runs, plus long holds on request
  initial begin
    int hold_left;
    int holds_done;
    int run_left;
    logic rdy_on;
    hold_left = 0;
    holds_done = 0;
    run_left = 0;
    rdy_on = 1'b1;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && holds_done != hold_requests) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        if (run_left == 0) begin
          rdy_on = !rdy_on || rsp_stall_max == 0;
          run_left = rdy_on ? $urandom_range(1, 8) : $urandom_range(1, rsp_stall_max);
        end
        run_left--;
        rsp_ch.ready <= rdy_on;
      end
    end
  end

  task automatic send_word(input logic [1:0] act, input logic [31:0] peer,
                           input logic [15:0] plen);
    @(negedge clk);
    req_ch.valid <= 1'b1;
    req_ch.action <= act;
    req_ch.peer_addr <= peer;
    req_ch.payload_length <= plen;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    pending_results.push_back(predict_lease_result(act, peer, plen));
  endtask

  task automatic idle_req(input int cycles);
    @(negedge clk);
    req_ch.valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // sender stops until every response is back, then lets the sequencer settle
  task automatic wait_drained();
    idle_req(1);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_announce_len(input logic [15:0] len);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= len;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    announce_len = len;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic test_directed_cases();
    logic [7:0] boards [8];
    boards = '{8'hFF, 8'h00, 8'd7, 8'd7, 8'd1, 8'd2, 8'd3, 8'd128};
    rsp_stall_max = 3;
    // empty lists, unused action, length mismatch (register still at reset)
    send_word(ACT_LEASE, 32'h0, 16'h0);
    send_word(ACT_RELEASE, peer_for(8'h00), 16'h0);
    send_word(ACT_UNUSED, 32'hFFFF_FFFF, 16'hFFFF);
    send_word(ACT_ANNOUNCE, peer_for(8'd9), 16'hFFFF);
    // fill the free stack, first with an all-ones address, then one too many
    send_word(ACT_ANNOUNCE, 32'hFFFF_FFFF, 16'h0);
    for (int i = 1; i < 8; i++) send_word(ACT_ANNOUNCE, peer_for(boards[i]), 16'h0);
    send_word(ACT_ANNOUNCE, peer_for(8'd9), 16'h0);
    // release into a full free stack drops the push
    send_word(ACT_LEASE, 32'h0, 16'h0);
    send_word(ACT_ANNOUNCE, peer_for(8'd200), 16'h0);
    send_word(ACT_RELEASE, peer_for(8'd128), 16'h0);
    // fill the busy list, then a grant whose append is dropped
    repeat (8) send_word(ACT_LEASE, $urandom, 16'($urandom));
    send_word(ACT_ANNOUNCE, peer_for(8'd42), 16'h0);
    send_word(ACT_LEASE, 32'hFFFF_FFFF, 16'hFFFF);
    // duplicate in busy list: only the first match goes
    send_word(ACT_RELEASE, peer_for(8'd7), 16'h0);
    wait_drained();
  endtask

  task automatic test_traffic_at_length(input logic [15:0] len, input int words,
                                        input int gap_max, input int stall_max);
    int burst_left;
    int sel;
    logic [1:0] act;
    logic [7:0] board;
    logic [15:0] plen;
    burst_left = 0;
    rsp_stall_max = stall_max;
    write_announce_len(len);
    for (int n = 0; n < words; n++) begin
      if (burst_left == 0) begin
        if (gap_max > 0) begin
          sel = $urandom_range(0, gap_max);
          if (sel > 0) idle_req(sel);
        end
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      sel = $urandom_range(0, 99);
      board = pick_board();
      plen = ($urandom_range(0, 99) < 85) ? announce_len : 16'($urandom);
      if (sel < 35) begin
        act = ACT_LEASE;
      end else if (sel < 65) begin
        act = ACT_RELEASE;
        if (busy_depth > 0 && $urandom_range(0, 3) != 0)
          board = busy_list[$urandom_range(0, busy_depth - 1)];
      end else if (sel < 95) begin
        act = ACT_ANNOUNCE;
      end else begin
        act = ACT_UNUSED;
      end
      send_word(act, peer_for(board), plen);
    end
    wait_drained();
  endtask

  // receiver holds off while requests keep coming; the block must stall
  task automatic test_output_backpressure();
    rsp_stall_max = 2;
    hold_requests++;
    for (int n = 0; n < 24; n++) begin
      if (n % 3 == 0) send_word(ACT_ANNOUNCE, peer_for(pick_board()), announce_len);
      else if (n % 3 == 1) send_word(ACT_LEASE, $urandom, 16'($urandom));
      else send_word(ACT_RELEASE, peer_for(pick_board()), 16'($urandom));
    end
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.action = ACT_LEASE;
    req_ch.peer_addr = '0;
    req_ch.payload_length = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    free_depth = 0;
    busy_depth = 0;
    announce_len = '0;
    mismatches = 0;
    rsp_stall_max = 0;
    hold_requests = 0;
    for (int i = 0; i < POOL_SIZE; i++) begin
      free_stack[i] = '0;
      busy_list[i] = '0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_traffic_at_length(16'hFFFF, 150, 6, 4);
    test_traffic_at_length(16'($urandom), 150, 0, 0);
    test_traffic_at_length(16'h0000, 200, 10, 10);
    test_output_backpressure();

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
